[src/pendulum_plant_iir_step_defines.svh]
// ----------------------------------------------------------------------------
// pendulum_plant_iir_step_defines.svh
// Assertion macros shared by the plant emulator RTL.
// ----------------------------------------------------------------------------
`ifndef PENDULUM_PLANT_IIR_STEP_DEFINES_SVH
`define PENDULUM_PLANT_IIR_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off while rst_n is low
`define PPIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plant emulator check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define PPIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plant emulator check failed");

`else

`define PPIS_ASSERT_NOW(label, ante, cons)
`define PPIS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/ppis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppis_pkg
// Types and constants of the pendulum plant emulator: data widths, register
// indexes, coefficient set and register reset values.
// ----------------------------------------------------------------------------
package ppis_pkg;

    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W  = 28;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_COEF_1  = 3'd0,
        CFG_FB_COEF_2  = 3'd1,
        CFG_FB_COEF_3  = 3'd2,
        CFG_FF_COEF_0  = 3'd3,
        CFG_FF_COEF_1  = 3'd4,
        CFG_FF_COEF_2  = 3'd5,
        CFG_FALL_LIMIT = 3'd6
    } cfg_index_t;

    typedef logic signed [DATA_W-1:0] sample_t;

    // Filter coefficients, signed Q3.28
    typedef struct packed {
        sample_t fb_coef_1;
        sample_t fb_coef_2;
        sample_t fb_coef_3;
        sample_t ff_coef_0;
        sample_t ff_coef_1;
        sample_t ff_coef_2;
    } coef_set_t;

    localparam coef_set_t COEF_RESET = '{
        fb_coef_1: 32'sd782757790,
        fb_coef_2: -32'sd760209211,
        fb_coef_3: 32'sd245752660,
        ff_coef_0: 32'sd460367,
        ff_coef_1: -32'sd13349,
        ff_coef_2: -32'sd446945
    };

    localparam logic [LIMIT_W-1:0] FALL_LIMIT_RESET = 31'd348966093;

endpackage

[src/ppis_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppis_mac
// Difference-equation datapath: six signed 32x32 products summed exactly,
// rounded to Q3.28 (half up) and saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module ppis_mac (
    input  ppis_pkg::coef_set_t coef,
    input  ppis_pkg::sample_t   angle_hist [3],
    input  ppis_pkg::sample_t   drive_cur,
    input  ppis_pkg::sample_t   drive_hist [2],
    output ppis_pkg::sample_t   angle_sat
);

    localparam int PROD_W = 2 * ppis_pkg::DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Q_W    = SUM_W - ppis_pkg::FRAC_W;

    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(1) << (ppis_pkg::FRAC_W - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(2147483647);
    localparam logic signed [Q_W-1:0] Q_MIN = -(Q_W'(64'sd2147483648));

    logic signed [PROD_W-1:0] prod [6];
    logic signed [SUM_W-1:0]  prod_ext [6];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_rnd;
    logic signed [Q_W-1:0]    q;

    // Form the six products in parallel
    always_comb
    begin
        prod[0] = coef.fb_coef_1 * angle_hist[0];
        prod[1] = coef.fb_coef_2 * angle_hist[1];
        prod[2] = coef.fb_coef_3 * angle_hist[2];
        prod[3] = coef.ff_coef_0 * drive_cur;
        prod[4] = coef.ff_coef_1 * drive_hist[0];
        prod[5] = coef.ff_coef_2 * drive_hist[1];
        for (int i = 0; i < 6; i++)
        begin
            prod_ext[i] = {{(SUM_W - PROD_W){prod[i][PROD_W-1]}}, prod[i]};
        end
    end

    // Sum exactly, round half up, drop the fraction
    assign sum = prod_ext[0] + prod_ext[1] + prod_ext[2]
               + prod_ext[3] + prod_ext[4] + prod_ext[5];
    assign sum_rnd = sum + ROUND_HALF;
    assign q = sum_rnd[SUM_W-1:ppis_pkg::FRAC_W];

    // Clamp to the 32-bit range
    always_comb
    begin
        priority if (q > Q_MAX)
        begin
            angle_sat = Q_MAX[ppis_pkg::DATA_W-1:0];
        end
        else if (q < Q_MIN)
        begin
            angle_sat = Q_MIN[ppis_pkg::DATA_W-1:0];
        end
        else
        begin
            angle_sat = q[ppis_pkg::DATA_W-1:0];
        end
    end

endmodule

[src/pendulum_plant_iir_step.sv]
`timescale 1ns / 1ps
// Timing: a drive passes the input register, then the six-multiply sum into
//   the result register; a stall on the result channel holds it in between.
// Throughput: one item per cycle while out_ready holds; the angle history closes its loop in that cycle.
// Reset: rst_n clears histories, tick phase and fall flag, and loads the
//   coefficient and limit reset values. No clearing pass.
// ----------------------------------------------------------------------------
// pendulum_plant_iir_step
// Plant emulator tick: third-order difference equation on angle and drive,
// sticky fall detection with angle hold, periodic publish marker.
// ----------------------------------------------------------------------------
`include "pendulum_plant_iir_step_defines.svh"

module pendulum_plant_iir_step #(
    parameter int PUBLISH_PERIOD = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppis_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppis_pkg::DATA_W-1:0]          cfg_data,
    // drive channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ppis_pkg::DATA_W-1:0]   drive,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ppis_pkg::DATA_W-1:0]   angle,
    output logic                                 fell,
    output logic                                 publish
);

    localparam int PHASE_W = $clog2(PUBLISH_PERIOD + 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PUBLISH_PERIOD - 1);

    ppis_pkg::coef_set_t                  coef_reg;
    logic [ppis_pkg::LIMIT_W-1:0]         limit_reg;

    logic                                 s1_valid_reg;
    ppis_pkg::sample_t                    drive_s1_reg;

    ppis_pkg::sample_t                    angle_hist_reg [3];
    ppis_pkg::sample_t                    drive_hist_reg [2];
    logic [PHASE_W-1:0]                   phase_reg;
    logic [PHASE_W-1:0]                   phase_next;
    logic                                 fallen_reg;
    logic                                 fallen_next;

    logic                                 out_valid_reg;
    ppis_pkg::sample_t                    angle_reg;
    ppis_pkg::sample_t                    angle_next;
    logic                                 fell_reg;
    logic                                 publish_reg;
    logic                                 publish_next;

    ppis_pkg::sample_t                    mac_angle;
    logic signed [ppis_pkg::DATA_W:0]     mac_abs;
    logic                                 over_limit;
    logic                                 advance;
    logic                                 load;

    // Handshake: the result register frees when empty or taken
    assign advance   = !out_valid_reg || out_ready;
    assign load      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= ppis_pkg::COEF_RESET;
            limit_reg <= ppis_pkg::FALL_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ppis_pkg::cfg_index_t'(cfg_index))
                ppis_pkg::CFG_FB_COEF_1:  coef_reg.fb_coef_1 <= cfg_data;
                ppis_pkg::CFG_FB_COEF_2:  coef_reg.fb_coef_2 <= cfg_data;
                ppis_pkg::CFG_FB_COEF_3:  coef_reg.fb_coef_3 <= cfg_data;
                ppis_pkg::CFG_FF_COEF_0:  coef_reg.ff_coef_0 <= cfg_data;
                ppis_pkg::CFG_FF_COEF_1:  coef_reg.ff_coef_1 <= cfg_data;
                ppis_pkg::CFG_FF_COEF_2:  coef_reg.ff_coef_2 <= cfg_data;
                ppis_pkg::CFG_FALL_LIMIT: limit_reg <= cfg_data[ppis_pkg::LIMIT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Input stage: hold a drive until the result register takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_s1_reg <= drive;
        end
    end

    // Filter datapath
    ppis_mac u_mac (
        .coef       (coef_reg),
        .angle_hist (angle_hist_reg),
        .drive_cur  (drive_s1_reg),
        .drive_hist (drive_hist_reg),
        .angle_sat  (mac_angle)
    );

    // Fall test, magnitude strictly above the limit
    always_comb
    begin
        if (mac_angle[ppis_pkg::DATA_W-1])
        begin
            mac_abs = -{mac_angle[ppis_pkg::DATA_W-1], mac_angle};
        end
        else
        begin
            mac_abs = {1'b0, mac_angle};
        end
        over_limit = mac_abs > $signed({2'b00, limit_reg});
    end

    // Next result and tick phase
    always_comb
    begin
        if (fallen_reg)
        begin
            angle_next  = angle_hist_reg[0];
            fallen_next = 1'b1;
        end
        else
        begin
            angle_next  = mac_angle;
            fallen_next = over_limit;
        end
        if (phase_reg >= PHASE_LAST)
        begin
            publish_next = 1'b1;
            phase_next   = '0;
        end
        else
        begin
            publish_next = 1'b0;
            phase_next   = phase_reg + PHASE_W'(1);
        end
    end

    // Plant state: advance on every result load, freeze histories after a fall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_hist_reg[0] <= '0;
            angle_hist_reg[1] <= '0;
            angle_hist_reg[2] <= '0;
            drive_hist_reg[0] <= '0;
            drive_hist_reg[1] <= '0;
            phase_reg         <= '0;
            fallen_reg        <= 1'b0;
        end
        else if (load)
        begin
            if (!fallen_reg)
            begin
                angle_hist_reg[2] <= angle_hist_reg[1];
                angle_hist_reg[1] <= angle_hist_reg[0];
                angle_hist_reg[0] <= mac_angle;
                drive_hist_reg[1] <= drive_hist_reg[0];
                drive_hist_reg[0] <= drive_s1_reg;
            end
            phase_reg  <= phase_next;
            fallen_reg <= fallen_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            angle_reg   <= angle_next;
            fell_reg    <= fallen_next;
            publish_reg <= publish_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;
    assign fell      = fell_reg;
    assign publish   = publish_reg;

    // Checks
    `PPIS_ASSERT_NEXT(a_fall_sticky, fallen_reg, fallen_reg)
    `PPIS_ASSERT_NEXT(a_hold_after_fall, fallen_reg, $stable(angle_hist_reg[0]))
    `PPIS_ASSERT_NOW(a_phase_range, 1'b1, phase_reg <= PHASE_LAST)
    `PPIS_ASSERT_NOW(a_fell_matches_state, out_valid_reg && !fell_reg, !fallen_reg)

endmodule

[tb/sv/pendulum_plant_iir_step_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_plant_iir_step_tb
// Self-checking bench for the plant emulator tick. A scoreboard class keeps
// its own copy of the coefficients, histories, tick phase and fall flag. It
// predicts angle, fell and publish for every drive transfer and compares each
// result transfer with the oldest prediction. Directed ticks cover the
// saturation extremes, rounding ties, the fall limit edge, taps and the
// ignored register index. Random phases run with and without idling on both
// channels and with a long receiver hold-off. A final phase trips the
// sticky fall and checks the held angle.
// ----------------------------------------------------------------------------
module pendulum_plant_iir_step_tb;

    localparam int          PUBLISH_PERIOD  = 10;
    localparam int          HOLD_OFF_CYCLES = 60;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned PHASE_ITEMS     = 370;

    // Index past the last register; writes to it must be ignored
    localparam logic [ppis_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam ppis_pkg::sample_t              Q_ONE     = 32'sd268435456;
    localparam ppis_pkg::sample_t              Q_MAX     = 32'sh7FFFFFFF;
    localparam ppis_pkg::sample_t              Q_MIN     = 32'sh80000000;
    localparam logic [ppis_pkg::LIMIT_W-1:0]   LIMIT_MAX = '1;

    localparam logic signed [67:0]   ROUND_HALF = 68'sd134217728;
    localparam logic signed [67:0]   SAT_HI     = 68'sd2147483647;
    localparam logic signed [67:0]   SAT_LO     = -68'sd2147483648;

    typedef struct packed {
        ppis_pkg::sample_t angle;
        logic              fell;
        logic              publish;
    } tick_result_t;

    // ------------------------------------------------------------------------
    // Plant predictor and expected-tick store
    // ------------------------------------------------------------------------
    class plant_scoreboard;
        ppis_pkg::coef_set_t          coefs;
        logic [ppis_pkg::LIMIT_W-1:0] fall_limit;
        ppis_pkg::sample_t            angle_hist [3];
        ppis_pkg::sample_t            drive_hist [2];
        int unsigned                  tick_phase;
        bit                           fallen;
        tick_result_t                 expected_q [$];
        int unsigned                  errors;

        function new();
            coefs      = ppis_pkg::COEF_RESET;
            fall_limit = ppis_pkg::FALL_LIMIT_RESET;
            angle_hist = '{default: '0};
            drive_hist = '{default: '0};
            tick_phase = 0;
            fallen     = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [ppis_pkg::CFG_IDX_W-1:0] idx,
                                logic [ppis_pkg::DATA_W-1:0] data);
            case (ppis_pkg::cfg_index_t'(idx))
                ppis_pkg::CFG_FB_COEF_1:  coefs.fb_coef_1 = data;
                ppis_pkg::CFG_FB_COEF_2:  coefs.fb_coef_2 = data;
                ppis_pkg::CFG_FB_COEF_3:  coefs.fb_coef_3 = data;
                ppis_pkg::CFG_FF_COEF_0:  coefs.ff_coef_0 = data;
                ppis_pkg::CFG_FF_COEF_1:  coefs.ff_coef_1 = data;
                ppis_pkg::CFG_FF_COEF_2:  coefs.ff_coef_2 = data;
                ppis_pkg::CFG_FALL_LIMIT: fall_limit      = data[ppis_pkg::LIMIT_W-1:0];
                default:                  ;
            endcase
        endfunction

        // Full-precision Q7.56 product, widened for an exact six-term sum
        function logic signed [67:0] weigh(ppis_pkg::sample_t coef, ppis_pkg::sample_t x);
            logic signed [63:0] prod;
            prod = coef * x;
            return prod;
        endfunction

        function void note_drive(ppis_pkg::sample_t d);
            logic signed [67:0] acc;
            logic signed [67:0] mag;
            ppis_pkg::sample_t  ang;
            tick_result_t       r;
            if (!fallen) begin
                acc = weigh(coefs.fb_coef_1, angle_hist[0])
                    + weigh(coefs.fb_coef_2, angle_hist[1])
                    + weigh(coefs.fb_coef_3, angle_hist[2])
                    + weigh(coefs.ff_coef_0, d)
                    + weigh(coefs.ff_coef_1, drive_hist[0])
                    + weigh(coefs.ff_coef_2, drive_hist[1]);
                // round to nearest, ties toward +inf, then clamp to 32 bits
                acc = (acc + ROUND_HALF) >>> ppis_pkg::FRAC_W;
                if (acc > SAT_HI)
                    ang = Q_MAX;
                else if (acc < SAT_LO)
                    ang = Q_MIN;
                else
                    ang = acc[ppis_pkg::DATA_W-1:0];
                angle_hist[2] = angle_hist[1];
                angle_hist[1] = angle_hist[0];
                angle_hist[0] = ang;
                drive_hist[1] = drive_hist[0];
                drive_hist[0] = d;
                // trip strictly above the limit, on either side
                mag = ang;
                if (mag < 0)
                    mag = -mag;
                if (mag > $signed({37'd0, fall_limit}))
                    fallen = 1'b1;
            end
            else begin
                ang = angle_hist[0];
            end
            r.angle   = ang;
            r.fell    = fallen;
            r.publish = (tick_phase + 1 >= PUBLISH_PERIOD);
            tick_phase = r.publish ? 0 : tick_phase + 1;
            expected_q.push_back(r);
        endfunction

        function void check_result(ppis_pkg::sample_t a, logic f, logic p);
            tick_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result transfer with no tick pending: angle %0d fell %0b publish %0b",
                       a, f, p);
                return;
            end
            e = expected_q.pop_front();
            if (a !== e.angle) begin
                errors++;
                $error("angle: expected %0d, actual %0d", e.angle, a);
            end
            if (f !== e.fell) begin
                errors++;
                $error("fell: expected %0b, actual %0b", e.fell, f);
            end
            if (p !== e.publish) begin
                errors++;
                $error("publish: expected %0b, actual %0b", e.publish, p);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ppis_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ppis_pkg::DATA_W-1:0]     cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    ppis_pkg::sample_t               drive     = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    ppis_pkg::sample_t               angle;
    logic                            fell;
    logic                            publish;

    int unsigned           send_idle_pct = 0;
    int unsigned           stall_pct     = 0;
    bit                    hold_request  = 1'b0;
    int unsigned           hold_left     = 0;

    plant_scoreboard       board;

    pendulum_plant_iir_step #(
        .PUBLISH_PERIOD(PUBLISH_PERIOD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .drive     (drive),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle     (angle),
        .fell      (fell),
        .publish   (publish)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(angle, fell, publish);
    end

    // Cycle limit
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one drive value, hold it until the transfer, note it on transfer
    task automatic send_drive(input ppis_pkg::sample_t value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        drive    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_drive(value);
        @(negedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [ppis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppis_pkg::DATA_W-1:0]    data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // Stop offering, drain all ticks, then load a full register set
    task automatic reconfigure(input ppis_pkg::coef_set_t c,
                               input logic [ppis_pkg::LIMIT_W-1:0] lim);
        in_valid <= 1'b0;
        @(negedge clk);
        wait_drained();
        write_reg(ppis_pkg::CFG_FB_COEF_1, c.fb_coef_1);
        write_reg(ppis_pkg::CFG_FB_COEF_2, c.fb_coef_2);
        write_reg(ppis_pkg::CFG_FB_COEF_3, c.fb_coef_3);
        write_reg(ppis_pkg::CFG_FF_COEF_0, c.ff_coef_0);
        write_reg(ppis_pkg::CFG_FF_COEF_1, c.ff_coef_1);
        write_reg(ppis_pkg::CFG_FF_COEF_2, c.ff_coef_2);
        write_reg(ppis_pkg::CFG_FALL_LIMIT, {1'($urandom_range(1)), lim});
        write_reg(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Coefficients within +-1/8 each: the loop stays well inside the
    // 32-bit range, so the angle never saturates and never trips the limit
    function automatic ppis_pkg::sample_t small_coef();
        return ppis_pkg::sample_t'($urandom_range(32'd67108864)) - 32'sd33554432;
    endfunction

    function automatic ppis_pkg::coef_set_t stable_coefs();
        ppis_pkg::coef_set_t c;
        c.fb_coef_1 = small_coef();
        c.fb_coef_2 = small_coef();
        c.fb_coef_3 = small_coef();
        c.ff_coef_0 = small_coef();
        c.ff_coef_1 = small_coef();
        c.ff_coef_2 = small_coef();
        return c;
    endfunction

    task automatic run_phase(input int unsigned                  n_items,
                             input int unsigned                  idle_pct,
                             input int unsigned                  stall,
                             input ppis_pkg::coef_set_t          c,
                             input logic [ppis_pkg::LIMIT_W-1:0] lim,
                             input bit                           positive_only);
        reconfigure(c, lim);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            // pause the sender until every pending tick has come back
            if (i == n_items / 3)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                wait_drained();
            end
            // hold off the receiver while the sender keeps offering
            if (i == n_items / 2 && idle_pct == 0 && stall == 0)
                hold_request = 1'b1;
            if (positive_only)
                send_drive(ppis_pkg::sample_t'($urandom_range(Q_MAX)));
            else
                send_drive(ppis_pkg::sample_t'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        ppis_pkg::sample_t             seq [$];
        ppis_pkg::coef_set_t           c;
        logic [ppis_pkg::LIMIT_W-1:0]  lim;
        int unsigned                   idle_mode  [4];
        int unsigned                   stall_mode [4];

        idle_mode  = '{0, 75, 0, 10};
        stall_mode = '{0, 0, 75, 10};
        board = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients, small drives
        seq = '{32'sd0, 32'sd1048576, -32'sd1048576, 32'sd7};
        foreach (seq[i])
            send_drive(seq[i]);

        // Unity gain on the current drive: angle follows drive exactly
        c = '0;
        c.ff_coef_0 = Q_ONE;
        reconfigure(c, LIMIT_MAX);
        seq = '{Q_MAX, -Q_MAX, 32'sd0, -32'sd1, 32'sd1};
        foreach (seq[i])
            send_drive(seq[i]);

        // Smallest gain: rounding ties go toward +inf
        c.ff_coef_0 = 32'sd1;
        reconfigure(c, LIMIT_MAX);
        seq = '{32'sd134217728, -32'sd134217728, -32'sd134217729, 32'sd134217727, Q_MAX};
        foreach (seq[i])
            send_drive(seq[i]);

        // Most negative gain times most negative drive: positive saturation
        c.ff_coef_0 = Q_MIN;
        reconfigure(c, LIMIT_MAX);
        seq = '{Q_MIN, 32'sd3, 32'sd0};
        foreach (seq[i])
            send_drive(seq[i]);

        // Impulse through every tap
        c = '{32'sd134217728, -32'sd67108864, 32'sd33554432,
              Q_ONE, -32'sd134217728, 32'sd67108864};
        reconfigure(c, LIMIT_MAX);
        seq = '{32'sd1000, 32'sd0, 32'sd0, 32'sd0};
        foreach (seq[i])
            send_drive(seq[i]);

        // Random drives under each idling pattern
        for (int m = 0; m < 4; m++)
            run_phase(PHASE_ITEMS, idle_mode[m], stall_mode[m], stable_coefs(), LIMIT_MAX, 1'b0);

        // Flush histories to zero, then drive hard into positive saturation
        reconfigure('0, LIMIT_MAX);
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (3) send_drive(32'sd0);
        c.fb_coef_1 = Q_MAX;
        c.fb_coef_2 = ppis_pkg::sample_t'($urandom_range(Q_MAX));
        c.fb_coef_3 = ppis_pkg::sample_t'($urandom_range(Q_MAX));
        c.ff_coef_0 = ppis_pkg::sample_t'($urandom_range(Q_MAX));
        c.ff_coef_1 = ppis_pkg::sample_t'($urandom_range(Q_MAX));
        c.ff_coef_2 = ppis_pkg::sample_t'($urandom_range(Q_MAX));
        run_phase(150, 10, 10, c, LIMIT_MAX, 1'b1);

        // Fall limit edge: a magnitude equal to the limit does not trip
        lim = ppis_pkg::LIMIT_W'($urandom_range(32'd1073741824, 32'd268435456));
        c = '0;
        c.ff_coef_0 = Q_ONE;
        reconfigure(c, lim);
        send_drive(ppis_pkg::sample_t'(lim));
        send_drive(-ppis_pkg::sample_t'(lim));

        // Negative saturation trips the sticky fall
        c.ff_coef_0 = Q_MAX;
        reconfigure(c, lim);
        send_drive(Q_MIN);

        // After the fall: angle held, publish keeps its period
        c = '{Q_MIN, Q_MIN, Q_MIN, ppis_pkg::sample_t'($urandom),
              ppis_pkg::sample_t'($urandom), ppis_pkg::sample_t'($urandom)};
        run_phase(60, 10, 10, c, ppis_pkg::LIMIT_W'($urandom), 1'b0);

        in_valid <= 1'b0;
        @(negedge clk);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[pendulum_plant_iir_step.f]
+incdir+src
src/ppis_pkg.sv
src/ppis_mac.sv
src/pendulum_plant_iir_step.sv
tb/sv/pendulum_plant_iir_step_tb.sv
